>>> rtl/sal_pkg.sv
// sal_pkg: shared constants, codes and command type for the sorted array list.
// Used by every module of the block; depends on nothing.
package sal_pkg;

  localparam int CAPACITY  = 16;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 4;
  localparam int WHERE_W   = 4;
  localparam int ENTRIES_W = 5;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DEL_POS = 2'd1,
    OP_DEL_VAL = 2'd2,
    OP_SEARCH  = 2'd3
  } sal_op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_POS   = 3'd4
  } sal_status_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } sal_cmd_t;

endpackage

>>> rtl/sal_ctrl.sv
// sal_ctrl: handshake controller of the sorted array list.
// Depends on sal_pkg; drives capture and execute commands to sal_dp.
module sal_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sal_pkg::sal_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   exec_fire;

  assign in_ready_o    = (state_q == S_IDLE);
  assign exec_fire     = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = in_valid_i && in_ready_o;
  assign cmd_o.execute = exec_fire;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (exec_fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/sal_dp.sv
// sal_dp: row of compare-and-shift cells, entry count and result register.
// Depends on sal_pkg; steered by sal_ctrl through sal_cmd_t.
module sal_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sal_pkg::sal_cmd_t                 cmd_i,
  input  logic [1:0]                        op_i,
  input  logic signed [sal_pkg::VALUE_W-1:0] value_i,
  input  logic [sal_pkg::POS_W-1:0]         position_i,
  output logic [2:0]                        status_o,
  output logic [sal_pkg::WHERE_W-1:0]       where_o,
  output logic signed [sal_pkg::VALUE_W-1:0] item_value_o,
  output logic [sal_pkg::ENTRIES_W-1:0]     entries_o
);

  localparam int Cap = sal_pkg::CAPACITY;

  logic signed [sal_pkg::VALUE_W-1:0] cell_q [Cap];
  logic signed [sal_pkg::VALUE_W-1:0] up_nb  [Cap];
  logic signed [sal_pkg::VALUE_W-1:0] dn_nb  [Cap];
  logic [sal_pkg::CNT_W-1:0]          count_q, count_d;

  sal_pkg::sal_op_e                   op_q;
  logic signed [sal_pkg::VALUE_W-1:0] val_q;
  logic [sal_pkg::POS_W-1:0]          pos_q;
  logic [Cap-1:0]                     gt_q, eq_q, gt_d, eq_d;

  sal_pkg::sal_status_e               status_q, status_d;
  logic [sal_pkg::WHERE_W-1:0]        where_q, where_d;
  logic signed [sal_pkg::VALUE_W-1:0] item_q, item_d;

  logic [sal_pkg::IDX_W-1:0]          gt_idx, eq_idx, ins_idx, rm_idx;
  logic                               do_insert, do_remove;

  function automatic logic [sal_pkg::IDX_W-1:0] first_set(input logic [Cap-1:0] v);
    logic [sal_pkg::IDX_W-1:0] idx;
    idx = '0;
    for (int k = Cap - 1; k >= 0; k--) begin
      if (v[k]) idx = sal_pkg::IDX_W'(k);
    end
    return idx;
  endfunction

  // flags against the current contents, taken as the item is accepted
  always_comb begin
    for (int k = 0; k < Cap; k++) begin
      gt_d[k] = (sal_pkg::CNT_W'(k) < count_q) && (cell_q[k] > value_i);
      eq_d[k] = (sal_pkg::CNT_W'(k) < count_q) && (cell_q[k] == value_i);
    end
  end

  generate
    for (genvar k = 0; k < Cap; k++) begin : g_nb
      if (k == 0) begin : g_first
        assign up_nb[k] = val_q;
      end else begin : g_up
        assign up_nb[k] = cell_q[k-1];
      end
      if (k == Cap - 1) begin : g_last
        assign dn_nb[k] = cell_q[k];
      end else begin : g_dn
        assign dn_nb[k] = cell_q[k+1];
      end
    end
  endgenerate

  assign gt_idx  = first_set(gt_q);
  assign eq_idx  = first_set(eq_q);
  assign ins_idx = (|gt_q) ? gt_idx : sal_pkg::IDX_W'(count_q);
  assign rm_idx  = (op_q == sal_pkg::OP_DEL_POS) ? sal_pkg::IDX_W'(pos_q) : eq_idx;

  always_comb begin
    status_d  = sal_pkg::ST_OK;
    where_d   = '0;
    item_d    = val_q;
    count_d   = count_q;
    do_insert = 1'b0;
    do_remove = 1'b0;
    case (op_q)
      sal_pkg::OP_INSERT: begin
        if (int'(count_q) >= Cap) begin
          status_d = sal_pkg::ST_FULL;
        end else begin
          do_insert = 1'b1;
          where_d   = sal_pkg::WHERE_W'(ins_idx);
          count_d   = count_q + 1'b1;
        end
      end
      sal_pkg::OP_DEL_POS: begin
        where_d = sal_pkg::WHERE_W'(pos_q);
        if (int'(pos_q) >= int'(count_q)) begin
          status_d = sal_pkg::ST_BAD_POS;
        end else begin
          do_remove = 1'b1;
          item_d    = cell_q[rm_idx];
          count_d   = count_q - 1'b1;
        end
      end
      sal_pkg::OP_DEL_VAL, sal_pkg::OP_SEARCH: begin
        if (count_q == '0) begin
          status_d = sal_pkg::ST_EMPTY;
        end else if (!(|eq_q)) begin
          status_d = sal_pkg::ST_NOT_FOUND;
        end else begin
          where_d = sal_pkg::WHERE_W'(eq_idx);
          if (op_q == sal_pkg::OP_DEL_VAL) begin
            do_remove = 1'b1;
            count_d   = count_q - 1'b1;
          end
        end
      end
      default: status_d = sal_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= sal_pkg::sal_op_e'(op_i);
      val_q <= value_i;
      pos_q <= position_i;
      gt_q  <= gt_d;
      eq_q  <= eq_d;
    end
    if (cmd_i.execute) begin
      status_q <= status_d;
      where_q  <= where_d;
      item_q   <= item_d;
      for (int k = 0; k < Cap; k++) begin
        if (do_insert && (sal_pkg::IDX_W'(k) > ins_idx)) begin
          cell_q[k] <= up_nb[k];
        end else if (do_insert && (sal_pkg::IDX_W'(k) == ins_idx)) begin
          cell_q[k] <= val_q;
        end else if (do_remove && (sal_pkg::IDX_W'(k) >= rm_idx)) begin
          cell_q[k] <= dn_nb[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  assign status_o     = status_q;
  assign where_o      = where_q;
  assign item_value_o = item_q;
  assign entries_o    = sal_pkg::ENTRIES_W'(count_q);

endmodule

>>> rtl/sorted_array_list.sv
// sorted_array_list: ascending list of signed 32-bit values with insert,
// delete and search. The compare flags are registered when the input item
// is accepted; once the output is free, the cells shift and the result
// register loads. A new item is taken only after the last one executes.
// Reset: asynchronous, active low; empties the list, clears pending results.
// Depends on sal_pkg, sal_ctrl and sal_dp.
module sorted_array_list (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         op_i,
  input  logic signed [sal_pkg::VALUE_W-1:0] value_i,
  input  logic [sal_pkg::POS_W-1:0]          position_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [2:0]                         status_o,
  output logic [sal_pkg::WHERE_W-1:0]        where_o,
  output logic signed [sal_pkg::VALUE_W-1:0] item_value_o,
  output logic [sal_pkg::ENTRIES_W-1:0]      entries_o
);

  sal_pkg::sal_cmd_t cmd;

  sal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  sal_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .op_i         (op_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .status_o     (status_o),
    .where_o      (where_o),
    .item_value_o (item_value_o),
    .entries_o    (entries_o)
  );

endmodule

>>> rtl/sal_checker.sv
// sal_checker: port-level assertions for sorted_array_list, bound to the top.
// Depends on sal_pkg.
module sal_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [1:0]                         op_i,
  input logic signed [sal_pkg::VALUE_W-1:0] value_i,
  input logic [sal_pkg::POS_W-1:0]          position_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [2:0]                         status_o,
  input logic [sal_pkg::WHERE_W-1:0]        where_o,
  input logic signed [sal_pkg::VALUE_W-1:0] item_value_o,
  input logic [sal_pkg::ENTRIES_W-1:0]      entries_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(where_o) && $stable(item_value_o) && $stable(entries_o))
    else $error("result changed while stalled");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == sal_pkg::ST_FULL) |->
    (int'(entries_o) == (sal_pkg::CAPACITY % 32)))
    else $error("full status with list not full");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == sal_pkg::ST_EMPTY) |-> (entries_o == '0))
    else $error("empty status with entries present");

  a_ok_where: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == sal_pkg::ST_OK) && (sal_pkg::CAPACITY <= 16) |->
    (int'(where_o) <= int'(entries_o)))
    else $error("position beyond list on success");

endmodule

bind sorted_array_list sal_checker u_sal_checker (.*);
